// ===== src/ltsm_pkg.sv =====
// Shared types, command codes and constants of the line table state machine.
package ltsm_pkg;

    // Field widths
    localparam int OP_W      = 8;
    localparam int OPERAND_W = 64;
    localparam int ADDR_W    = 64;
    localparam int WORD_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int VER_W     = 3;

    // Stream payload widths (whole bytes)
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 208;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_VERSION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPCODE_BASE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BASE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_RANGE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INST_LENGTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OPS_PER_INST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_IS_STMT  = 3'd6;

    // Reset values of the configuration registers
    localparam logic [VER_W-1:0]  RST_FORMAT_VERSION   = 3'd4;
    localparam logic [BYTE_W-1:0] RST_OPCODE_BASE      = 8'd13;
    localparam logic [BYTE_W-1:0] RST_LINE_BASE        = 8'hFB;
    localparam logic [BYTE_W-1:0] RST_LINE_RANGE       = 8'd14;
    localparam logic [BYTE_W-1:0] RST_MIN_INST_LENGTH  = 8'd1;
    localparam logic [BYTE_W-1:0] RST_MAX_OPS_PER_INST = 8'd1;
    localparam logic              RST_DEFAULT_IS_STMT  = 1'b1;

    // Opcode numbers
    localparam logic [OP_W-1:0] OP_EXTENDED        = 8'd0;
    localparam logic [OP_W-1:0] OP_COPY            = 8'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE_PC      = 8'd2;
    localparam logic [OP_W-1:0] OP_ADVANCE_LINE    = 8'd3;
    localparam logic [OP_W-1:0] OP_SET_FILE        = 8'd4;
    localparam logic [OP_W-1:0] OP_SET_COLUMN      = 8'd5;
    localparam logic [OP_W-1:0] OP_NEGATE_STMT     = 8'd6;
    localparam logic [OP_W-1:0] OP_SET_BASIC_BLOCK = 8'd7;
    localparam logic [OP_W-1:0] OP_CONST_ADD_PC    = 8'd8;
    localparam logic [OP_W-1:0] OP_FIXED_ADV_PC    = 8'd9;
    localparam logic [OP_W-1:0] OP_SET_PROLOGUE    = 8'd10;
    localparam logic [OP_W-1:0] OP_SET_EPILOGUE    = 8'd11;
    localparam logic [OP_W-1:0] OP_SET_ISA         = 8'd12;
    localparam logic [OP_W-1:0] EXT_END_SEQUENCE   = 8'd1;
    localparam logic [OP_W-1:0] EXT_SET_ADDRESS    = 8'd2;
    localparam logic [OP_W-1:0] EXT_SET_DISCRIM    = 8'd4;

    // Queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // Command kinds handed from front to back
    typedef logic [4:0] kind_t;
    localparam kind_t K_NOP       = 5'd0;
    localparam kind_t K_END       = 5'd1;
    localparam kind_t K_SET_ADDR  = 5'd2;
    localparam kind_t K_SET_DISC  = 5'd3;
    localparam kind_t K_COPY      = 5'd4;
    localparam kind_t K_ADV_PC    = 5'd5;
    localparam kind_t K_ADV_LINE  = 5'd6;
    localparam kind_t K_SET_FILE  = 5'd7;
    localparam kind_t K_SET_COL   = 5'd8;
    localparam kind_t K_NEG_STMT  = 5'd9;
    localparam kind_t K_BB        = 5'd10;
    localparam kind_t K_CONST_ADD = 5'd11;
    localparam kind_t K_FIX_ADV   = 5'd12;
    localparam kind_t K_PROLOGUE  = 5'd13;
    localparam kind_t K_EPILOGUE  = 5'd14;
    localparam kind_t K_SET_ISA   = 5'd15;
    localparam kind_t K_SPECIAL   = 5'd16;

    typedef struct packed {
        kind_t                 kind;
        logic [BYTE_W-1:0]     adj;
        logic [OPERAND_W-1:0]  operand;
    } cmd_t;

    typedef struct packed {
        logic [VER_W-1:0]  format_version;
        logic [BYTE_W-1:0] opcode_base;
        logic [BYTE_W-1:0] line_base;
        logic [BYTE_W-1:0] line_range;
        logic [BYTE_W-1:0] min_inst_length;
        logic [BYTE_W-1:0] max_ops_per_inst;
        logic              default_is_stmt;
    } cfg_t;

endpackage

// ===== src/ltsm_front.sv =====
// Front end: decodes accepted instructions into commands for the back end.
module ltsm_front import ltsm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_data
);

    logic [OP_W-1:0]      op;
    logic [OP_W-1:0]      ext_op;
    logic [OPERAND_W-1:0] operand;
    logic                 v_ge3;
    logic                 v_ge4;
    kind_t                kind;
    logic [BYTE_W-1:0]    adj;
    logic                 accept;
    logic [31:0]          item_cnt_reg;
    logic [31:0]          item_cnt_next;

    assign op      = s_tdata[7:0];
    assign ext_op  = s_tdata[15:8];
    assign operand = s_tdata[79:16];
    assign v_ge3   = cfg.format_version > 3'd2;
    assign v_ge4   = cfg.format_version > 3'd3;

    // Classify the instruction
    always_comb begin
        kind = K_NOP;
        adj  = '0;
        if (op == OP_EXTENDED) begin
            if (ext_op == EXT_END_SEQUENCE) begin
                kind = K_END;
            end else if (ext_op == EXT_SET_ADDRESS) begin
                kind = K_SET_ADDR;
            end else if (ext_op == EXT_SET_DISCRIM && v_ge4) begin
                kind = K_SET_DISC;
            end
        end else if (op < cfg.opcode_base) begin
            case (op)
                OP_COPY:            kind = K_COPY;
                OP_ADVANCE_PC:      kind = K_ADV_PC;
                OP_ADVANCE_LINE:    kind = K_ADV_LINE;
                OP_SET_FILE:        kind = K_SET_FILE;
                OP_SET_COLUMN:      kind = K_SET_COL;
                OP_NEGATE_STMT:     kind = K_NEG_STMT;
                OP_SET_BASIC_BLOCK: kind = K_BB;
                OP_CONST_ADD_PC: begin
                    kind = K_CONST_ADD;
                    adj  = ~cfg.opcode_base;
                end
                OP_FIXED_ADV_PC:    kind = K_FIX_ADV;
                OP_SET_PROLOGUE:    kind = v_ge3 ? K_PROLOGUE : K_NOP;
                OP_SET_EPILOGUE:    kind = v_ge3 ? K_EPILOGUE : K_NOP;
                OP_SET_ISA:         kind = v_ge3 ? K_SET_ISA : K_NOP;
                default:            kind = K_NOP;
            endcase
        end else begin
            kind = K_SPECIAL;
            adj  = op - cfg.opcode_base;
        end
    end

    // Accept while the queue has room; drop instructions that do nothing
    assign s_tready     = !q_full;
    assign accept       = s_tvalid && s_tready;
    assign q_push       = accept && (kind != K_NOP);
    assign q_data.kind    = kind;
    assign q_data.adj     = adj;
    assign q_data.operand = operand;

    // Count accepted transactions (status for debug)
    assign item_cnt_next = item_cnt_reg + 32'd1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_cnt_reg <= '0;
        end else if (accept) begin
            item_cnt_reg <= item_cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full) else $error("push into full queue");
    a_nop_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && kind == K_NOP) |-> !q_push) else $error("nop pushed");
    a_cnt_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> item_cnt_reg == $past(item_cnt_next)) else $error("count slip");
`endif

endmodule

// ===== src/ltsm_queue.sv =====
// Short command queue between front and back ends.
module ltsm_queue import ltsm_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = cnt_reg == CNT_W'(DEPTH);
    assign empty = cnt_reg == '0;
    assign head  = mem[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("pop from empty queue");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> !full) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH)) else $error("count out of range");
`endif

endmodule

// ===== src/ltsm_div.sv =====
// Serial divider: 64-bit dividend by 8-bit divisor, eight quotient bits a cycle.
module ltsm_div import ltsm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [OPERAND_W-1:0]  dividend,
    input  logic [BYTE_W-1:0]     divisor,
    output logic                  busy,
    output logic                  done,
    output logic [OPERAND_W-1:0]  quot,
    output logic [BYTE_W-1:0]     rem
);

    localparam int STEPS = OPERAND_W / BYTE_W;
    localparam int CNT_W = $clog2(STEPS);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [OPERAND_W-1:0]  dvd_reg, dvd_next;
    logic [BYTE_W-1:0]     rem_reg, rem_next;
    logic [BYTE_W-1:0]     dsr_reg, dsr_next;
    logic [OPERAND_W-1:0]  x;
    logic [BYTE_W-1:0]     r;
    logic [BYTE_W:0]       t;

    // Eight restoring steps on the partial remainder
    always_comb begin
        x = dvd_reg;
        r = rem_reg;
        t = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            t = {r, x[OPERAND_W-1]};
            x = {x[OPERAND_W-2:0], 1'b0};
            if (t >= {1'b0, dsr_reg}) begin
                t    = t - {1'b0, dsr_reg};
                x[0] = 1'b1;
            end
            r = t[BYTE_W-1:0];
        end
    end

    // Sequence the steps
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            dvd_next = x;
            rem_next = r;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = dvd_reg;
    assign rem  = rem_reg;

`ifndef NO_ASSERTIONS
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("done held");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("done without run");
    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> rem_reg < dsr_reg) else $error("remainder too large");
`endif

endmodule

// ===== src/ltsm_back.sv =====
// Back end: row registers, address arithmetic and row output register.
module ltsm_back import ltsm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 q_empty,
    input  cmd_t                 q_head,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV1 = 3'd1;
    localparam logic [2:0] S_DIV2 = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;

    logic [2:0]            state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [ADDR_W-1:0]     adv_reg, adv_next;
    logic [ADDR_W-1:0]     prod_reg, prod_next;
    logic [BYTE_W-1:0]     lrem_reg, lrem_next;

    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [BYTE_W-1:0]     opidx_reg, opidx_next;
    logic [WORD_W-1:0]     file_reg, file_next;
    logic [WORD_W-1:0]     line_reg, line_next;
    logic [WORD_W-1:0]     col_reg, col_next;
    logic [BYTE_W-1:0]     isa_reg, isa_next;
    logic [WORD_W-1:0]     disc_reg, disc_next;
    logic                  stmt_reg, stmt_next;
    logic                  bb_reg, bb_next;
    logic                  pe_reg, pe_next;
    logic                  eb_reg, eb_next;

    logic                  mv_reg, mv_next;
    logic [M_TDATA_W-1:0]  mdata_reg, mdata_next;
    logic                  mlast_reg, mlast_next;

    logic                  v_ge4;
    logic [BYTE_W-1:0]     lr_eff;
    logic [BYTE_W-1:0]     mo_eff;
    logic                  out_free;
    logic                  head_emits;
    logic                  row_load;
    logic [WORD_W-1:0]     line_spec;
    logic [ADDR_W-1:0]     addr_sum;

    logic                  div_start;
    logic [OPERAND_W-1:0]  div_dividend;
    logic [BYTE_W-1:0]     div_divisor;
    logic                  div_busy;
    logic                  div_done;
    logic [OPERAND_W-1:0]  div_quot;
    logic [BYTE_W-1:0]     div_rem;

    assign v_ge4      = cfg.format_version > 3'd3;
    assign lr_eff     = (cfg.line_range == '0) ? 8'd1 : cfg.line_range;
    assign mo_eff     = (cfg.max_ops_per_inst == '0) ? 8'd1 : cfg.max_ops_per_inst;
    assign out_free   = !mv_reg || m_tready;
    assign head_emits = (q_head.kind == K_COPY) || (q_head.kind == K_END);
    assign q_pop      = (state_reg == S_IDLE) && !q_empty && (!head_emits || out_free);
    assign addr_sum   = addr_reg + prod_reg;
    assign line_spec  = line_reg + {{(WORD_W-BYTE_W){cfg.line_base[BYTE_W-1]}}, cfg.line_base}
                        + {{(WORD_W-BYTE_W){1'b0}}, lrem_reg};

    ltsm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // Execute commands
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        adv_next     = adv_reg;
        prod_next    = prod_reg;
        lrem_next    = lrem_reg;
        addr_next    = addr_reg;
        opidx_next   = opidx_reg;
        file_next    = file_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        isa_next     = isa_reg;
        disc_next    = disc_reg;
        stmt_next    = stmt_reg;
        bb_next      = bb_reg;
        pe_next      = pe_reg;
        eb_next      = eb_reg;
        mv_next      = mv_reg && !m_tready;
        mdata_next   = mdata_reg;
        mlast_next   = mlast_reg;
        row_load     = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = mo_eff;

        case (state_reg)
            S_IDLE: begin
                if (q_pop) begin
                    cmd_next = q_head;
                    case (q_head.kind)
                        K_END, K_COPY: begin
                            row_load   = 1'b1;
                            mlast_next = q_head.kind == K_END;
                            mdata_next = {4'b0, eb_reg, pe_reg, bb_reg, stmt_reg, file_reg,
                                          disc_reg, isa_reg, col_reg, line_reg, addr_reg};
                            disc_next  = '0;
                            bb_next    = 1'b0;
                            pe_next    = 1'b0;
                            eb_next    = 1'b0;
                            if (q_head.kind == K_END) begin
                                addr_next  = '0;
                                opidx_next = '0;
                                file_next  = 32'd1;
                                line_next  = 32'd1;
                                col_next   = '0;
                                isa_next   = '0;
                                stmt_next  = cfg.default_is_stmt;
                            end
                        end
                        K_SET_ADDR: begin
                            addr_next  = q_head.operand;
                            opidx_next = '0;
                        end
                        K_SET_DISC: disc_next = q_head.operand[WORD_W-1:0];
                        K_ADV_LINE: line_next = line_reg + q_head.operand[WORD_W-1:0];
                        K_SET_FILE: file_next = q_head.operand[WORD_W-1:0];
                        K_SET_COL:  col_next  = q_head.operand[WORD_W-1:0];
                        K_NEG_STMT: stmt_next = !stmt_reg;
                        K_BB:       bb_next   = 1'b1;
                        K_FIX_ADV: begin
                            addr_next  = addr_reg + {48'b0, q_head.operand[15:0]};
                            opidx_next = '0;
                        end
                        K_PROLOGUE: pe_next  = 1'b1;
                        K_EPILOGUE: eb_next  = 1'b1;
                        K_SET_ISA:  isa_next = q_head.operand[BYTE_W-1:0];
                        K_ADV_PC: begin
                            if (v_ge4) begin
                                div_start    = 1'b1;
                                div_dividend = {56'b0, opidx_reg} + q_head.operand;
                                state_next   = S_DIV2;
                            end else begin
                                adv_next   = q_head.operand;
                                state_next = S_MUL;
                            end
                        end
                        K_CONST_ADD, K_SPECIAL: begin
                            div_start    = 1'b1;
                            div_dividend = {56'b0, q_head.adj};
                            div_divisor  = lr_eff;
                            state_next   = S_DIV1;
                        end
                        default: ;
                    endcase
                end
            end
            // Line step: quotient advances ops, remainder goes to the line
            S_DIV1: begin
                if (div_done) begin
                    lrem_next = div_rem;
                    if (v_ge4) begin
                        div_start    = 1'b1;
                        div_dividend = {56'b0, opidx_reg} + div_quot;
                        state_next   = S_DIV2;
                    end else begin
                        adv_next   = div_quot;
                        state_next = S_MUL;
                    end
                end
            end
            // Op-index split into instructions and remaining ops
            S_DIV2: begin
                if (div_done) begin
                    adv_next   = div_quot;
                    opidx_next = div_rem;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                prod_next  = 64'({56'b0, cfg.min_inst_length} * adv_reg);
                state_next = S_ADD;
            end
            S_ADD: begin
                if (cmd_reg.kind == K_SPECIAL) begin
                    if (out_free) begin
                        row_load   = 1'b1;
                        mlast_next = 1'b0;
                        mdata_next = {4'b0, eb_reg, pe_reg, bb_reg, stmt_reg, file_reg,
                                      disc_reg, isa_reg, col_reg, line_spec, addr_sum};
                        addr_next  = addr_sum;
                        line_next  = line_spec;
                        disc_next  = '0;
                        bb_next    = 1'b0;
                        pe_next    = 1'b0;
                        eb_next    = 1'b0;
                        state_next = S_IDLE;
                    end
                end else begin
                    addr_next  = addr_sum;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (row_load) begin
            mv_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
            addr_reg  <= '0;
            opidx_reg <= '0;
            file_reg  <= 32'd1;
            line_reg  <= 32'd1;
            col_reg   <= '0;
            isa_reg   <= '0;
            disc_reg  <= '0;
            stmt_reg  <= RST_DEFAULT_IS_STMT;
            bb_reg    <= 1'b0;
            pe_reg    <= 1'b0;
            eb_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            addr_reg  <= addr_next;
            opidx_reg <= opidx_next;
            file_reg  <= file_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            isa_reg   <= isa_next;
            disc_reg  <= disc_next;
            stmt_reg  <= stmt_next;
            bb_reg    <= bb_next;
            pe_reg    <= pe_next;
            eb_reg    <= eb_next;
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        adv_reg   <= adv_next;
        prod_reg  <= prod_next;
        lrem_reg  <= lrem_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

`ifndef NO_ASSERTIONS
    a_row_free: assert property (@(posedge aclk) disable iff (!aresetn)
        row_load |-> out_free) else $error("row overwrites pending row");
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy) else $error("divider restarted while busy");
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV1 || state_reg == S_DIV2) |-> (div_busy || div_done))
        else $error("waiting on idle divider");
    a_end_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_head.kind == K_END) |=> (line_reg == 32'd1 && addr_reg == '0))
        else $error("sequence not restarted");
`endif

endmodule

// ===== src/line_table_state_machine.sv =====
// Top level of the line table state machine: configuration registers and wiring.
//
// Executes one line-number program instruction per input transaction and
// emits a row on copy, special opcodes and end_sequence (tlast marks the
// end_sequence row). Simple instructions complete in the back end's idle
// state. advance_pc splits the op-index in the shared serial divider with
// op-index versions (4 and up), then multiplies and adds; special opcodes
// and const_add_pc first divide for the line step. Special opcodes also
// wait for the result channel to take the previous row. The serial
// divider produces eight quotient bits a cycle over a 64-bit dividend. A
// short queue lets the front keep accepting while the back end works.
module line_table_state_machine import ltsm_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // op[7:0], ext_op[15:8], operand[79:16]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // row_address[63:0], row_line[95:64], row_column[127:96], row_isa[135:128],
    // row_discriminator[167:136], row_file_index[199:168], row_is_stmt[200],
    // row_basic_block[201], row_prologue_end[202], row_epilogue_begin[203]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic q_full, q_push, q_pop, q_empty;
    cmd_t q_in, q_head;

    // Write configuration registers
    assign cfg_ready = 1'b1;
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_FORMAT_VERSION:   cfg_next.format_version   = cfg_data[VER_W-1:0];
                CFG_OPCODE_BASE:      cfg_next.opcode_base      = cfg_data;
                CFG_LINE_BASE:        cfg_next.line_base        = cfg_data;
                CFG_LINE_RANGE:       cfg_next.line_range       = cfg_data;
                CFG_MIN_INST_LENGTH:  cfg_next.min_inst_length  = cfg_data;
                CFG_MAX_OPS_PER_INST: cfg_next.max_ops_per_inst = cfg_data;
                CFG_DEFAULT_IS_STMT:  cfg_next.default_is_stmt  = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.format_version   <= RST_FORMAT_VERSION;
            cfg_reg.opcode_base      <= RST_OPCODE_BASE;
            cfg_reg.line_base        <= RST_LINE_BASE;
            cfg_reg.line_range       <= RST_LINE_RANGE;
            cfg_reg.min_inst_length  <= RST_MIN_INST_LENGTH;
            cfg_reg.max_ops_per_inst <= RST_MAX_OPS_PER_INST;
            cfg_reg.default_is_stmt  <= RST_DEFAULT_IS_STMT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ltsm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    ltsm_queue #(.DEPTH(QDEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    ltsm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the line table state machine: directed table plus random programs.
`timescale 1ns / 1ps

module testbench;
    import ltsm_pkg::*;

    typedef struct packed {
        logic [63:0] address;
        logic [31:0] line;
        logic [31:0] column;
        logic [7:0]  isa;
        logic [31:0] discrim;
        logic [31:0] file;
        logic        is_stmt;
        logic        basic_block;
        logic        end_seq;
        logic        prologue;
        logic        epilogue;
    } row_t;

    typedef struct {
        logic [7:0]  op;
        logic [7:0]  ext;
        logic [63:0] operand;
        logic        has_row;   // typed-in expectation present
        logic [63:0] address;
        logic [31:0] line;
        logic        end_seq;
    } vec_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    line_table_state_machine u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor copy of configuration and row registers
    cfg_t        shadow_cfg;
    logic [63:0] st_address;
    logic [7:0]  st_op_index;
    logic [31:0] st_file;
    logic [31:0] st_line;
    logic [31:0] st_column;
    logic [7:0]  st_isa;
    logic [31:0] st_discrim;
    logic        st_is_stmt;
    logic        st_bb;
    logic        st_prologue;
    logic        st_epilogue;

    row_t pending_rows[$];
    int   error_count = 0;
    int   rows_seen = 0;
    int   items_sent = 0;
    int   cycle_count = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("line_table_state_machine verification failed");
            $finish;
        end
    end

    task automatic start_sequence();
        st_address  = '0;
        st_op_index = '0;
        st_file     = 32'd1;
        st_line     = 32'd1;
        st_column   = '0;
        st_isa      = '0;
        st_discrim  = '0;
        st_is_stmt  = shadow_cfg.default_is_stmt;
        st_bb       = 1'b0;
        st_prologue = 1'b0;
        st_epilogue = 1'b0;
    endtask

    task automatic advance_address(input logic [63:0] adv);
        logic [63:0] divisor;
        logic [63:0] sum;
        divisor = (shadow_cfg.max_ops_per_inst == 0) ? 64'd1 : 64'(shadow_cfg.max_ops_per_inst);
        if (shadow_cfg.format_version > 3) begin
            sum = 64'(st_op_index) + adv;
            st_address  = st_address + 64'(shadow_cfg.min_inst_length) * (sum / divisor);
            st_op_index = 8'(sum % divisor);
        end else begin
            st_address = st_address + 64'(shadow_cfg.min_inst_length) * adv;
        end
    endtask

    function automatic row_t current_row(input logic end_seq);
        row_t r;
        r.address = st_address;   r.line = st_line;       r.column = st_column;
        r.isa = st_isa;           r.discrim = st_discrim; r.file = st_file;
        r.is_stmt = st_is_stmt;   r.basic_block = st_bb;  r.end_seq = end_seq;
        r.prologue = st_prologue; r.epilogue = st_epilogue;
        return r;
    endfunction

    // Apply one instruction to the predicted row registers; push any emitted row
    task automatic execute_instruction(input logic [7:0] op, input logic [7:0] ext,
                                       input logic [63:0] v, output logic emitted);
        logic [7:0]  adj;
        logic [7:0]  range_eff;
        logic [31:0] base_ext;
        emitted = 1'b0;
        range_eff = (shadow_cfg.line_range == 0) ? 8'd1 : shadow_cfg.line_range;
        if (op == OP_EXTENDED) begin
            if (ext == EXT_END_SEQUENCE) begin
                pending_rows.push_back(current_row(1'b1));
                emitted = 1'b1;
                start_sequence();
            end else if (ext == EXT_SET_ADDRESS) begin
                st_address = v;
                st_op_index = '0;
            end else if (ext == EXT_SET_DISCRIM && shadow_cfg.format_version > 3) begin
                st_discrim = v[31:0];
            end
        end else if (op < shadow_cfg.opcode_base) begin
            case (op)
                OP_COPY: begin
                    pending_rows.push_back(current_row(1'b0));
                    emitted = 1'b1;
                    st_discrim = '0; st_bb = 1'b0; st_prologue = 1'b0; st_epilogue = 1'b0;
                end
                OP_ADVANCE_PC:      advance_address(v);
                OP_ADVANCE_LINE:    st_line = st_line + v[31:0];
                OP_SET_FILE:        st_file = v[31:0];
                OP_SET_COLUMN:      st_column = v[31:0];
                OP_NEGATE_STMT:     st_is_stmt = ~st_is_stmt;
                OP_SET_BASIC_BLOCK: st_bb = 1'b1;
                OP_CONST_ADD_PC: begin
                    adj = 8'd255 - shadow_cfg.opcode_base;
                    advance_address(64'(adj / range_eff));
                end
                OP_FIXED_ADV_PC: begin
                    st_address = st_address + 64'(v[15:0]);
                    st_op_index = '0;
                end
                OP_SET_PROLOGUE: if (shadow_cfg.format_version > 2) st_prologue = 1'b1;
                OP_SET_EPILOGUE: if (shadow_cfg.format_version > 2) st_epilogue = 1'b1;
                OP_SET_ISA:      if (shadow_cfg.format_version > 2) st_isa = v[7:0];
                default: ;
            endcase
        end else begin
            adj = op - shadow_cfg.opcode_base;
            base_ext = {{24{shadow_cfg.line_base[7]}}, shadow_cfg.line_base};
            advance_address(64'(adj / range_eff));
            st_line = st_line + base_ext + 32'(adj % range_eff);
            pending_rows.push_back(current_row(1'b0));
            emitted = 1'b1;
            st_discrim = '0; st_bb = 1'b0; st_prologue = 1'b0; st_epilogue = 1'b0;
        end
    endtask

    // Write one configuration register and mirror it
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FORMAT_VERSION:   shadow_cfg.format_version = value[2:0];
            CFG_OPCODE_BASE:      shadow_cfg.opcode_base = value;
            CFG_LINE_BASE:        shadow_cfg.line_base = value;
            CFG_LINE_RANGE:       shadow_cfg.line_range = value;
            CFG_MIN_INST_LENGTH:  shadow_cfg.min_inst_length = value;
            CFG_MAX_OPS_PER_INST: shadow_cfg.max_ops_per_inst = value;
            CFG_DEFAULT_IS_STMT:  shadow_cfg.default_is_stmt = value[0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Hold until every expected row has come, then let the back end drain
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (40) @(negedge aclk);
    endtask

    // Send one instruction, with a random gap ahead of it when gaps is set
    task automatic send_instruction(input logic [7:0] op, input logic [7:0] ext,
                                    input logic [63:0] v, input logic gaps);
        logic emitted;
        int   gap;
        gap = gaps ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {v, ext, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        execute_instruction(op, ext, v, emitted);
        items_sent++;
        @(negedge aclk);
    endtask

    // Receiver: random stalls, stretches without them
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!m_tready) begin
                stall = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
                repeat (stall) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (m_tvalid) begin
                m_tready <= ($urandom_range(0, 2) == 0) ? 1'b0 : 1'b1;
            end
        end
    end

    // Compare each accepted row with the oldest expectation
    always @(posedge aclk) begin
        row_t e;
        row_t a;
        if (aresetn && m_tvalid && m_tready) begin
            a.address = m_tdata[63:0];       a.line = m_tdata[95:64];
            a.column = m_tdata[127:96];      a.isa = m_tdata[135:128];
            a.discrim = m_tdata[167:136];    a.file = m_tdata[199:168];
            a.is_stmt = m_tdata[200];        a.basic_block = m_tdata[201];
            a.prologue = m_tdata[202];       a.epilogue = m_tdata[203];
            a.end_seq = m_tlast;
            rows_seen++;
            if (pending_rows.size() == 0) begin
                $display("%0t: unexpected row, actual %p", $time, a);
                error_count++;
            end else begin
                e = pending_rows.pop_front();
                if (e !== a) begin
                    $display("%0t: row mismatch, expected %p, actual %p", $time, e, a);
                    error_count++;
                end
            end
        end
    end

    // Directed table; typed-in rows are checked against the predictor on the fly
    vec_t directed[] = '{
        '{OP_COPY, 8'd0, 64'd0, 1'b1, 64'd0, 32'd1, 1'b0},
        '{OP_EXTENDED, EXT_END_SEQUENCE, 64'd0, 1'b1, 64'd0, 32'd1, 1'b1},
        '{OP_EXTENDED, EXT_SET_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0, 0, 0},
        '{OP_COPY, 8'd0, 64'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 1'b0},
        '{OP_ADVANCE_PC, 8'd0, 64'd1, 1'b0, 0, 0, 0},
        '{OP_ADVANCE_LINE, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0, 0, 0},
        '{OP_COPY, 8'd0, 64'd0, 1'b1, 64'd0, 32'd0, 1'b0},
        '{OP_SET_FILE, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0, 0, 0},
        '{OP_SET_COLUMN, 8'd0, 64'hFFFF_FFFF_0000_FFFF, 1'b0, 0, 0, 0},
        '{OP_NEGATE_STMT, 8'd0, 64'd0, 1'b0, 0, 0, 0},
        '{OP_SET_BASIC_BLOCK, 8'd0, 64'd0, 1'b0, 0, 0, 0},
        '{OP_SET_PROLOGUE, 8'd0, 64'd0, 1'b0, 0, 0, 0},
        '{OP_SET_EPILOGUE, 8'd0, 64'd0, 1'b0, 0, 0, 0},
        '{OP_SET_ISA, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0, 0, 0},
        '{OP_EXTENDED, EXT_SET_DISCRIM, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0, 0, 0},
        '{OP_COPY, 8'd0, 64'd0, 1'b0, 0, 0, 0},
        '{OP_CONST_ADD_PC, 8'd0, 64'd0, 1'b0, 0, 0, 0},
        '{OP_FIXED_ADV_PC, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0, 0, 0},
        '{8'd13, 8'd0, 64'd0, 1'b0, 0, 0, 0},
        '{8'd255, 8'd0, 64'd0, 1'b0, 0, 0, 0},
        '{8'd0, 8'd3, 64'd0, 1'b0, 0, 0, 0},
        '{8'd0, 8'd255, 64'd0, 1'b0, 0, 0, 0},
        '{OP_EXTENDED, EXT_END_SEQUENCE, 64'd0, 1'b0, 0, 0, 0}
    };

    // Configuration sets walked by the random part: version, base, line base, range,
    // min length, max ops, default is_stmt
    logic [7:0] settings[8][7] = '{
        '{8'd4, 8'd13, 8'hFB, 8'd14, 8'd1, 8'd1, 8'd1},
        '{8'd2, 8'd10, 8'h80, 8'd1, 8'd255, 8'd255, 8'd0},
        '{8'd5, 8'd255, 8'h7F, 8'd255, 8'd4, 8'd3, 8'd1},
        '{8'd3, 8'd1, 8'h00, 8'd0, 8'd2, 8'd0, 8'd0},
        '{8'd4, 8'd0, 8'hFD, 8'd12, 8'd1, 8'd4, 8'd1},
        '{8'd7, 8'd20, 8'hFF, 8'd7, 8'd3, 8'd2, 8'd0},
        '{8'd0, 8'd5, 8'h01, 8'd3, 8'd1, 8'd1, 8'd1},
        '{8'd6, 8'd13, 8'hFB, 8'd14, 8'd8, 8'd255, 8'd0}
    };

    function automatic logic [63:0] random_operand();
        case ($urandom_range(0, 3))
            0:       return {$urandom, $urandom};
            1:       return 64'($urandom_range(0, 40));
            2:       return -64'($urandom_range(1, 40));
            default: return {32'h0, $urandom};
        endcase
    endfunction

    initial begin
        logic [7:0]  op;
        logic [7:0]  ext;
        logic [7:0]  base_now;
        int          phase;
        int          local_errors;
        s_tvalid = 1'b0; s_tdata = '0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        aresetn = 1'b0;
        local_errors = 0;
        shadow_cfg = '{RST_FORMAT_VERSION, RST_OPCODE_BASE, RST_LINE_BASE, RST_LINE_RANGE,
                       RST_MIN_INST_LENGTH, RST_MAX_OPS_PER_INST, RST_DEFAULT_IS_STMT};
        start_sequence();
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // Directed rows at reset settings, with typed-in checks where obvious
        foreach (directed[i]) begin
            if (directed[i].has_row) begin
                if (st_address !== directed[i].address || st_line !== directed[i].line) begin
                    $display("%0t: directed row %0d, expected addr %h line %h, actual %h %h",
                             $time, i, directed[i].address, directed[i].line,
                             st_address, st_line);
                    local_errors++;
                end
            end
            send_instruction(directed[i].op, directed[i].ext, directed[i].operand, i[0]);
        end
        // Version 2 ignores the newer opcodes; late default_is_stmt write
        wait_drained();
        write_register(CFG_FORMAT_VERSION, 8'd2);
        write_register(CFG_DEFAULT_IS_STMT, 8'd0);
        send_instruction(OP_SET_PROLOGUE, 8'd0, 64'd0, 1'b0);
        send_instruction(OP_SET_ISA, 8'd0, 64'd9, 1'b0);
        send_instruction(OP_EXTENDED, EXT_SET_DISCRIM, 64'd5, 1'b0);
        send_instruction(OP_COPY, 8'd0, 64'd0, 1'b0);
        send_instruction(OP_EXTENDED, EXT_END_SEQUENCE, 64'd0, 1'b0);
        send_instruction(OP_COPY, 8'd0, 64'd0, 1'b0);

        // Random programs, one configuration set per phase
        for (phase = 0; phase < 8; phase++) begin
            wait_drained();
            for (int r = 0; r < 7; r++) write_register(CFG_IDX_W'(r), settings[phase][r]);
            base_now = shadow_cfg.opcode_base;
            for (int n = 0; n < 92; n++) begin
                ext = 8'($urandom);
                case ($urandom_range(0, 9))
                    0, 1, 2: op = (base_now == 8'd255) ? 8'd255
                                  : 8'($urandom_range(base_now, 255));
                    3:       op = OP_EXTENDED;
                    4:       begin op = OP_EXTENDED; ext = 8'($urandom_range(1, 4)); end
                    5:       op = 8'($urandom);
                    default: op = 8'($urandom_range(1, 12));
                endcase
                if ($urandom_range(0, 30) == 0) begin
                    op = OP_EXTENDED; ext = EXT_END_SEQUENCE;
                end
                send_instruction(op, ext, random_operand(), (phase % 3) != 0);
            end
            send_instruction(OP_EXTENDED, EXT_END_SEQUENCE, 64'd0, 1'b0);
        end

        wait_drained();
        repeat (60) @(posedge aclk);
        if (pending_rows.size() != 0) begin
            $display("%0t: %0d expected rows never arrived", $time, pending_rows.size());
            local_errors++;
        end
        $display("Ran %0d instructions over nine register settings, %0d rows compared.",
                 items_sent, rows_seen);
        if (error_count == 0 && local_errors == 0) begin
            $display("line_table_state_machine verification clean");
        end else begin
            $display("line_table_state_machine verification failed");
        end
        $finish;
    end

endmodule
